@@ rtl/e2c_pkg.sv @@
// Shared types, constants and helpers for the epoch seconds to calendar block.
// No dependencies; used by e2c_core and epoch_seconds_to_calendar.

package e2c_pkg;

	localparam int unsigned EPOCH_W = 32;
	localparam int unsigned DAYS_W  = 16;
	localparam int unsigned REM_W   = 6;

	localparam logic [EPOCH_W-1:0] SEC_PER_MIN   = 32'd60;
	localparam logic [EPOCH_W-1:0] MIN_PER_HOUR  = 32'd60;
	localparam logic [EPOCH_W-1:0] HOUR_PER_DAY  = 32'd24;
	localparam logic [EPOCH_W-1:0] DAYS_PER_WEEK = 32'd7;
	localparam logic [DAYS_W-1:0]  YEAR_NORM     = 16'd365;
	localparam logic [DAYS_W-1:0]  YEAR_LEAP     = 16'd366;

	// 1970-01-01 was a Thursday
	localparam logic [EPOCH_W-1:0] WDAY_OFFSET = 32'd4;

	// quotient = (n * MAG) >> SH, exact over each operand range met here
	localparam logic [EPOCH_W-1:0] MAG_60 = 32'h8888_8889;
	localparam logic [EPOCH_W-1:0] MAG_24 = 32'hAAAA_AAAB;
	localparam logic [EPOCH_W-1:0] MAG_7  = 32'h0001_2493;
	localparam int unsigned        SH_60  = 37;
	localparam int unsigned        SH_24  = 36;
	localparam int unsigned        SH_7   = 19;

	// 1970 mod 4, mod 100 and mod 400
	localparam logic [1:0] Y4_INIT   = 2'd2;
	localparam logic [6:0] Y100_INIT = 7'd70;
	localparam logic [8:0] Y400_INIT = 9'd370;
	localparam logic [6:0] Y100_LAST = 7'd99;
	localparam logic [8:0] Y400_LAST = 9'd399;

	localparam logic [7:0] YR_MAX   = 8'd255;
	localparam logic [7:0] YR_TOP   = 8'd136;
	localparam logic [3:0] MON_LAST = 4'd11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_YEAR,
		ST_MONTH,
		ST_FIN
	} e2c_state_t;

	typedef enum logic [1:0] {
		DV_SEC,
		DV_MIN,
		DV_HOUR,
		DV_WDAY
	} e2c_div_t;

	typedef struct packed {
		logic idle;
		logic done;
	} e2c_stat_t;

	typedef struct packed {
		logic [4:0] day_of_month;
		logic [3:0] month;
		logic [7:0] year_offset;
		logic [2:0] weekday;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} e2c_res_t;

	// month index from 0
	function automatic logic [DAYS_W-1:0] month_len(input logic [3:0] mon, input logic leap);
		logic [DAYS_W-1:0] len;
		unique case (mon)
			4'd1:                      len = leap ? 16'd29 : 16'd28;
			4'd3, 4'd5, 4'd8, 4'd10:   len = 16'd30;
			default:                   len = 16'd31;
		endcase
		return len;
	endfunction

endpackage

@@ rtl/epoch_seconds_to_calendar.sv @@
// Top level: stream ports and output register around the calendar sequencer.
// Depends on e2c_pkg and e2c_core.

// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into second,
// minute, hour, weekday (1 = Sunday), year offset from 1970, month and day,
// with Gregorian leap years. One request at a time. The year offset runs
// 0..136 and the whole months passed in that year 0..11. A finished result
// waits while the previous one still sits untaken in the output register.
// A shared multiplier and one compare-subtract unit do the work: reciprocal
// division by 60, 60, 24 and 7 (multiply, then subtract back), then the
// years and then the months are stepped off one at a time, a last compare
// closes each loop, and the output is loaded. tready returns once the
// result has moved to the output register, which holds it until taken.

module epoch_seconds_to_calendar
	import e2c_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // epoch_seconds[31:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata    // second[5:0], minute[11:6], hour[16:12],
	                                    // weekday[19:17], year_offset[27:20],
	                                    // month[31:28], day_of_month[36:32], zeros
);

	e2c_stat_t stat;
	e2c_res_t  res;
	logic      out_valid_q, out_free, load;
	logic [39:0] out_data_q;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign load          = stat.done && out_free;
	assign s_axis_tready = stat.idle;

	e2c_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (s_axis_tvalid),
		.epoch      (s_axis_tdata),
		.done_ready (out_free),
		.stat       (stat),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= {3'b000, res.day_of_month, res.month, res.year_offset,
				res.weekday, res.hour, res.minute, res.second};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

@@ rtl/e2c_core.sv @@
// Sequencer, shared multiplier and compare-subtract unit for the calendar breakdown.
// Depends on e2c_pkg.

module e2c_core
	import e2c_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [EPOCH_W-1:0] epoch,
	input  logic               done_ready,
	output e2c_stat_t          stat,
	output e2c_res_t           res
);

	e2c_state_t            state_q, state_d;
	e2c_div_t              sel_q;
	logic                  ph_q;
	logic [EPOCH_W-1:0]    n_q;
	logic [2*EPOCH_W-1:0]  prod_q, prod_nx;
	logic [DAYS_W-1:0]     days_q;
	logic [7:0]            yr_q;
	logic [3:0]            mon_q;
	logic [1:0]            y4_q;
	logic [6:0]            y100_q;
	logic [8:0]            y400_q;
	logic [5:0]            sec_q, min_q;
	logic [4:0]            hour_q;
	logic [2:0]            wday_q;

	logic [EPOCH_W-1:0]    mag, quot, back, div_b, op_a, op_b;
	logic [EPOCH_W:0]      diff;
	logic [REM_W-1:0]      rem;
	logic                  ge, leap, div_last, yr_step, mon_step;

	assign leap = (y4_q == 2'd0) && ((y100_q != 7'd0) || (y400_q == 9'd0));

	always_comb begin
		unique case (sel_q)
			DV_SEC: begin
				mag   = MAG_60;
				div_b = SEC_PER_MIN;
				quot  = EPOCH_W'(prod_q >> SH_60);
				back  = quot * SEC_PER_MIN;
			end
			DV_MIN: begin
				mag   = MAG_60;
				div_b = MIN_PER_HOUR;
				quot  = EPOCH_W'(prod_q >> SH_60);
				back  = quot * MIN_PER_HOUR;
			end
			DV_HOUR: begin
				mag   = MAG_24;
				div_b = HOUR_PER_DAY;
				quot  = EPOCH_W'(prod_q >> SH_24);
				back  = quot * HOUR_PER_DAY;
			end
			DV_WDAY: begin
				mag   = MAG_7;
				div_b = DAYS_PER_WEEK;
				quot  = EPOCH_W'(prod_q >> SH_7);
				back  = quot * DAYS_PER_WEEK;
			end
		endcase
	end

	assign prod_nx = {{EPOCH_W{1'b0}}, n_q} * {{EPOCH_W{1'b0}}, mag};

	// the shared compare-subtract unit
	always_comb begin
		unique case (state_q)
			ST_DIV: begin
				op_a = n_q;
				op_b = back;
			end
			ST_YEAR: begin
				op_a = {{(EPOCH_W-DAYS_W){1'b0}}, days_q};
				op_b = {{(EPOCH_W-DAYS_W){1'b0}}, (leap ? YEAR_LEAP : YEAR_NORM)};
			end
			default: begin
				op_a = {{(EPOCH_W-DAYS_W){1'b0}}, days_q};
				op_b = {{(EPOCH_W-DAYS_W){1'b0}}, month_len(mon_q, leap)};
			end
		endcase
		diff = {1'b0, op_a} - {1'b0, op_b};
		ge   = !diff[EPOCH_W];
	end

	assign rem      = diff[REM_W-1:0];
	assign div_last = ph_q && (sel_q == DV_WDAY);
	assign yr_step  = ge && (yr_q != YR_MAX);
	assign mon_step = ge && (mon_q != MON_LAST);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_d = ST_DIV;
			ST_DIV:   if (div_last) state_d = ST_YEAR;
			ST_YEAR:  if (!yr_step) state_d = ST_MONTH;
			ST_MONTH: if (!mon_step) state_d = ST_FIN;
			ST_FIN:   if (done_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		stat.idle = (state_q == ST_IDLE);
		stat.done = (state_q == ST_FIN);
		res.second       = sec_q;
		res.minute       = min_q;
		res.hour         = hour_q;
		res.weekday      = wday_q;
		res.year_offset  = yr_q;
		res.month        = mon_q + 4'd1;
		res.day_of_month = days_q[4:0] + 5'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= DV_SEC;
			ph_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				sel_q <= DV_SEC;
				ph_q  <= 1'b0;
			end else if (state_q == ST_DIV) begin
				ph_q <= ~ph_q;
				if (ph_q) begin
					unique case (sel_q)
						DV_SEC:  sel_q <= DV_MIN;
						DV_MIN:  sel_q <= DV_HOUR;
						DV_HOUR: sel_q <= DV_WDAY;
						DV_WDAY: sel_q <= DV_SEC;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					n_q <= epoch;
				end
			end
			ST_DIV: begin
				if (!ph_q) begin
					prod_q <= prod_nx;
				end else begin
					unique case (sel_q)
						DV_SEC: begin
							sec_q <= rem;
							n_q   <= quot;
						end
						DV_MIN: begin
							min_q <= rem;
							n_q   <= quot;
						end
						DV_HOUR: begin
							hour_q <= rem[4:0];
							days_q <= quot[DAYS_W-1:0];
							n_q    <= quot + WDAY_OFFSET;
						end
						DV_WDAY: begin
							wday_q <= rem[2:0] + 3'd1;
							yr_q   <= '0;
							y4_q   <= Y4_INIT;
							y100_q <= Y100_INIT;
							y400_q <= Y400_INIT;
						end
					endcase
				end
			end
			ST_YEAR: begin
				if (yr_step) begin
					days_q <= diff[DAYS_W-1:0];
					yr_q   <= yr_q + 8'd1;
					y4_q   <= y4_q + 2'd1;
					y100_q <= (y100_q == Y100_LAST) ? 7'd0 : y100_q + 7'd1;
					y400_q <= (y400_q == Y400_LAST) ? 9'd0 : y400_q + 9'd1;
				end else begin
					mon_q <= '0;
				end
			end
			ST_MONTH: begin
				if (mon_step) begin
					days_q <= diff[DAYS_W-1:0];
					mon_q  <= mon_q + 4'd1;
				end
			end
			default: ;
		endcase
	end

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && ph_q |-> ge && diff[EPOCH_W-1:0] < div_b)
		else $error("remainder not below divisor");

	a_year_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_YEAR |-> yr_q <= YR_TOP)
		else $error("year offset beyond 32-bit range");

	a_fin_date_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |-> mon_q <= MON_LAST && days_q < month_len(mon_q, leap))
		else $error("day outside its month");

	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && !done_ready |=> state_q == ST_FIN && $stable(days_q)
			&& $stable(mon_q) && $stable(yr_q))
		else $error("result lost while stalled");

endmodule

@@ test/calendar_checker.sv @@
// Watches both stream channels of epoch_seconds_to_calendar, predicts each date and compares.
// Depends on e2c_pkg for the result layout; instantiated by testbench.

module calendar_checker
	import e2c_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // epoch_seconds[31:0]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,   // second, minute, hour, weekday, year_offset,
	                                    // month, day_of_month, zeros
	output int          mismatches,
	output int          outstanding,
	output int          checked
);

	e2c_res_t pending_dates[$];
	e2c_res_t got_date;
	e2c_res_t want_date;
	int       err_count = 0;
	int       date_count = 0;

	function automatic logic year_is_leap(input int unsigned offset);
		int unsigned y;
		y = 1970 + offset;
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic e2c_res_t calendar_of(input logic [31:0] secs);
		int unsigned t;
		int unsigned days;
		int unsigned yr;
		int unsigned mon;
		int unsigned mlen;
		e2c_res_t    r;
		t = secs;
		r.second = 6'(t % 60);
		t = t / 60;
		r.minute = 6'(t % 60);
		t = t / 60;
		r.hour = 5'(t % 24);
		days = t / 24;
		// day zero was a Thursday
		r.weekday = 3'((days + 4) % 7 + 1);
		yr = 0;
		while (days >= (year_is_leap(yr) ? 366 : 365)) begin
			days = days - (year_is_leap(yr) ? 366 : 365);
			yr = yr + 1;
		end
		mon = 0;
		while (mon < 11) begin
			case (mon)
				1: begin
					mlen = year_is_leap(yr) ? 29 : 28;
				end
				3, 5, 8, 10: begin
					mlen = 30;
				end
				default: begin
					mlen = 31;
				end
			endcase
			if (days < mlen)
				break;
			days = days - mlen;
			mon = mon + 1;
		end
		r.year_offset = 8'(yr);
		r.month = 4'(mon + 1);
		r.day_of_month = 5'(days + 1);
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				pending_dates.push_back(calendar_of(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				got_date = e2c_res_t'(m_axis_tdata[36:0]);
				if (pending_dates.size() == 0) begin
					$error("result %h with no request outstanding", m_axis_tdata);
					err_count++;
				end else begin
					want_date = pending_dates.pop_front();
					date_count++;
					check_field("second", want_date.second, got_date.second);
					check_field("minute", want_date.minute, got_date.minute);
					check_field("hour", want_date.hour, got_date.hour);
					check_field("weekday", want_date.weekday, got_date.weekday);
					check_field("year_offset", want_date.year_offset, got_date.year_offset);
					check_field("month", want_date.month, got_date.month);
					check_field("day_of_month", want_date.day_of_month,
						got_date.day_of_month);
				end
			end
		end
		mismatches <= err_count;
		outstanding <= pending_dates.size();
		checked <= date_count;
	end

endmodule

@@ test/testbench.sv @@
// Top of the calendar conversion test: clock, reset, request and result stimulus, verdict.
// Depends on e2c_pkg, epoch_seconds_to_calendar and calendar_checker.

module testbench;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = 32'd0;    // epoch_seconds[31:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;            // second, minute, hour, weekday, year_offset,
	                                      // month, day_of_month, zeros
	int          mismatches;
	int          outstanding;
	int          checked;
	int          send_idle = 0;
	int          recv_stall = 0;
	int          hold_len = 0;

	always #2 clk = ~clk;

	epoch_seconds_to_calendar u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	calendar_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.checked       (checked)
	);

	// idle cycles go before the offer, so the accepting step never sees a second assignment
	task automatic send_time(input logic [31:0] secs);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= $urandom;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= secs;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic drain_results;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin
		#(20_000_000);
		$display("testbench failed");
		$finish;
	end

	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_len > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall);
				@(posedge clk);
			end
		end
	end

	initial begin
		logic [31:0] secs;
		int unsigned days;
		int unsigned yy;
		int unsigned pick;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// minute, hour and day roll-overs, leap days, century year, 32-bit ends
		send_time(32'd0);
		send_time(32'd59);
		send_time(32'd60);
		send_time(32'd3599);
		send_time(32'd3600);
		send_time(32'd86399);
		send_time(32'd86400);
		send_time(32'd31535999);
		send_time(32'd31536000);
		send_time(32'd68169599);
		send_time(32'd68169600);
		send_time(32'd68256000);
		send_time(32'd94694399);
		send_time(32'd94694400);
		send_time(32'd951782400);
		send_time(32'd978307199);
		send_time(32'd978307200);
		send_time(32'd1234567890);
		send_time(32'd2147483647);
		send_time(32'd2147483648);
		send_time(32'd4102444800);
		send_time(32'd4107542399);
		send_time(32'd4107542400);
		send_time(32'hFFFF_FFFF);
		drain_results();

		for (int i = 0; i < 1000; i++) begin
			case (i / 250)
				0: begin
					send_idle = 0;
					recv_stall = 0;
				end
				1: begin
					send_idle = 72;
					recv_stall = 0;
				end
				2: begin
					send_idle = 0;
					recv_stall = 72;
				end
				default: begin
					send_idle = 38;
					recv_stall = 38;
				end
			endcase
			if (i == 100)
				hold_len = 1500;
			if (i == 500)
				drain_results();
			case ($urandom_range(3))
				0, 1: begin
					secs = $urandom;
				end
				2: begin
					// day-aligned, biased to the first and last second of a day
					pick = $urandom_range(2);
					secs = $urandom_range(49710) * 86400;
					if (pick == 1)
						secs = secs + 86399;
					else if (pick == 2)
						secs = secs + $urandom_range(86399);
				end
				default: begin
					// within two days of a new year
					days = 0;
					yy = 1970 + $urandom_range(136);
					for (int unsigned y = 1970; y < yy; y++)
						days = days + (((y % 4 == 0) && ((y % 100 != 0) ||
							(y % 400 == 0))) ? 366 : 365);
					secs = days * 86400 - 172800 + $urandom_range(345600);
				end
			endcase
			send_time(secs);
		end

		drain_results();
		repeat (300) @(posedge clk);
		$display("%0d dates checked: epoch ends, roll-overs, leap and century days, random times",
			checked);
		$display("handshakes free-running, sender idle, result stalls, both, and one long hold");
		if (mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
